// ===== hdl/i2cees_pkg.sv =====
package i2cees_pkg;

  localparam int PAGE_BYTES_DEF = 128;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [1:0] CFG_DEVICE_SELECT = 2'd0;
  localparam logic [1:0] CFG_WIDE_ADDRESS  = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;

  localparam logic [7:0] DEVICE_SELECT_RST = 8'hA0;
  localparam logic       WIDE_ADDRESS_RST  = 1'b1;
  localparam logic [7:0] RETRY_LIMIT_RST   = 8'd200;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;
  localparam logic [7:0] ST_LOW_BITS  = 8'h07;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_SEND   = 3'd2;
  localparam logic [2:0] ACT_RX_ACK = 3'd3;
  localparam logic [2:0] ACT_RX_NAK = 3'd4;
  localparam logic [2:0] ACT_STOP   = 3'd5;

endpackage

// ===== hdl/i2c_eeprom_transaction_sequencer.sv =====
// An accepted request goes through the input register, then the result register, to result valid.
// Throughput: one request per cycle while out_stall is low; the phase and counter registers
// update in the same cycle as the result register, so the next request sees them at once.
// in_stall follows out_stall only while both the input and result registers are full.
// Reset (rst_n low, synchronous): sequencer idle, counters cleared, pipeline empty,
// configuration back to device select 0xA0, two address bytes, retry limit 200.
module i2c_eeprom_transaction_sequencer #(
  parameter int PAGE_BYTES = i2cees_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_mem_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_bus_status,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_bus_action,
  output logic [7:0]  out_tx_byte,
  output logic        out_write_taken,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_done_res,
  output logic        out_failed,
  output logic [15:0] out_byte_count
);

  // page offset = addr - floor(addr * MUL >> SHIFT) * PAGE_BYTES
  localparam int  PW    = $clog2(PAGE_BYTES);
  localparam int  RW    = PW + 1;
  localparam int  SHIFT = 16 + PW;
  localparam int  MW    = SHIFT - PW + 1;
  localparam int  PRW   = 16 + MW;
  localparam longint MUL = ((longint'(1) << SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam logic [RW-1:0] PAGE_R = RW'(PAGE_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_SLAW, PH_ADDR_HI, PH_ADDR_LO,
    PH_REP, PH_SLAR, PH_RX, PH_TX
  } phase_t;

  logic [7:0] dev_sel_r;
  logic       wide_r;
  logic [7:0] retry_r;

  logic        s1_valid_r;
  logic [1:0]  s1_command_r;
  logic [15:0] s1_address_r;
  logic [15:0] s1_length_r;
  logic [7:0]  s1_status_r;
  logic [7:0]  s1_rx_byte_r;
  logic [7:0]  s1_write_byte_r;
  logic [15:0] s1_quot_r;

  phase_t      phase_r, phase_nxt;
  logic        is_write_r, is_write_nxt;
  logic [15:0] cur_address_r, cur_address_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] transferred_r, transferred_nxt;
  logic [7:0]  attempts_r, attempts_nxt;

  logic        out_valid_r;
  logic [2:0]  out_action_r;
  logic [7:0]  out_tx_r;
  logic        out_taken_r;
  logic        out_rvalid_r;
  logic [7:0]  out_rbyte_r;
  logic        out_done_r;
  logic        out_failed_r;
  logic [15:0] out_count_r;

  logic            out_load;
  logic            s1_adv;
  logic            in_acc;
  logic [PRW-1:0]  quot_prod;
  logic [15:0]     quot_in;
  logic [15:0]     page_base;
  logic [PW-1:0]   page_off;
  logic [RW-1:0]   room;
  logic [7:0]      st;
  logic [7:0]      sel;
  logic [15:0]     rem_dec;
  logic [15:0]     len;
  logic [2:0]      act;
  logic [7:0]      tx;
  logic            taken;
  logic            rv;
  logic [7:0]      rb;
  logic            dn;
  logic            fl;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign quot_prod = PRW'(in_mem_address) * PRW'(MUL);
  assign quot_in   = 16'(quot_prod >> SHIFT);
  assign page_base = 16'(s1_quot_r * 16'(PAGE_BYTES));
  assign page_off  = PW'(s1_address_r - page_base);
  assign room      = PAGE_R - RW'(page_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_sel_r <= i2cees_pkg::DEVICE_SELECT_RST;
      wide_r    <= i2cees_pkg::WIDE_ADDRESS_RST;
      retry_r   <= i2cees_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cees_pkg::CFG_DEVICE_SELECT: dev_sel_r <= cfg_data;
        i2cees_pkg::CFG_WIDE_ADDRESS:  wide_r    <= cfg_data[0];
        i2cees_pkg::CFG_RETRY_LIMIT:   retry_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_acc) begin
      s1_command_r    <= in_command;
      s1_address_r    <= in_mem_address;
      s1_length_r     <= in_length;
      s1_status_r     <= in_bus_status;
      s1_rx_byte_r    <= in_rx_byte;
      s1_write_byte_r <= in_write_byte;
      s1_quot_r       <= quot_in;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    is_write_nxt    = is_write_r;
    cur_address_nxt = cur_address_r;
    remaining_nxt   = remaining_r;
    transferred_nxt = transferred_r;
    attempts_nxt    = attempts_r;
    act   = i2cees_pkg::ACT_NONE;
    tx    = 8'h00;
    taken = 1'b0;
    rv    = 1'b0;
    rb    = 8'h00;
    dn    = 1'b0;
    fl    = 1'b0;
    len   = s1_length_r;
    st    = s1_status_r & ~i2cees_pkg::ST_LOW_BITS;
    rem_dec = remaining_r - 16'd1;
    sel = dev_sel_r;
    if (!wide_r) begin
      sel[3:1] = sel[3:1] | cur_address_r[10:8];
    end

    case (s1_command_r)
      i2cees_pkg::CMD_READ, i2cees_pkg::CMD_WRITE: begin
        if (phase_r == PH_IDLE) begin
          cur_address_nxt = s1_address_r;
          is_write_nxt    = s1_command_r[0];
          transferred_nxt = 16'd0;
          if (s1_command_r == i2cees_pkg::CMD_WRITE && 16'(room) < s1_length_r) begin
            len = 16'(room);
          end
          remaining_nxt = len;
          if (retry_r == 8'd0) begin
            attempts_nxt = 8'd0;
            dn = 1'b1;
            fl = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            attempts_nxt = 8'd1;
            act = i2cees_pkg::ACT_START;
            phase_nxt = PH_START;
          end
        end
      end
      i2cees_pkg::CMD_EVENT: begin
        if (phase_r != PH_IDLE) begin
          case (phase_r)
            PH_START: begin
              if (st == i2cees_pkg::ST_START || st == i2cees_pkg::ST_REP_START) begin
                act = i2cees_pkg::ACT_SEND;
                tx = sel;
                phase_nxt = PH_SLAW;
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_SLAW: begin
              if (st == i2cees_pkg::ST_SLAW_ACK) begin
                act = i2cees_pkg::ACT_SEND;
                if (wide_r) begin
                  tx = cur_address_r[15:8];
                  phase_nxt = PH_ADDR_HI;
                end else begin
                  tx = cur_address_r[7:0];
                  phase_nxt = PH_ADDR_LO;
                end
              end else if (st == i2cees_pkg::ST_SLAW_NACK) begin
                if (attempts_r >= retry_r) begin
                  dn = 1'b1;
                  fl = 1'b1;
                  phase_nxt = PH_IDLE;
                end else begin
                  attempts_nxt = attempts_r + 8'd1;
                  act = i2cees_pkg::ACT_START;
                  phase_nxt = PH_START;
                end
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_ADDR_HI: begin
              if (st == i2cees_pkg::ST_DATA_ACK) begin
                act = i2cees_pkg::ACT_SEND;
                tx = cur_address_r[7:0];
                phase_nxt = PH_ADDR_LO;
              end else if (st == i2cees_pkg::ST_DATA_NACK) begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                phase_nxt = PH_IDLE;
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_ADDR_LO: begin
              if (st == i2cees_pkg::ST_DATA_ACK) begin
                if (!is_write_r) begin
                  act = i2cees_pkg::ACT_START;
                  phase_nxt = PH_REP;
                end else if (remaining_r != 16'd0) begin
                  act = i2cees_pkg::ACT_SEND;
                  tx = s1_write_byte_r;
                  taken = 1'b1;
                  phase_nxt = PH_TX;
                end else begin
                  act = i2cees_pkg::ACT_STOP;
                  dn = 1'b1;
                  phase_nxt = PH_IDLE;
                end
              end else if (st == i2cees_pkg::ST_DATA_NACK) begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                phase_nxt = PH_IDLE;
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_REP: begin
              if (st == i2cees_pkg::ST_START || st == i2cees_pkg::ST_REP_START) begin
                act = i2cees_pkg::ACT_SEND;
                tx = sel | 8'h01;
                phase_nxt = PH_SLAR;
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_SLAR: begin
              if (st == i2cees_pkg::ST_SLAR_ACK) begin
                if (remaining_r != 16'd0) begin
                  act = (remaining_r > 16'd1) ? i2cees_pkg::ACT_RX_ACK
                                              : i2cees_pkg::ACT_RX_NAK;
                  phase_nxt = PH_RX;
                end else begin
                  act = i2cees_pkg::ACT_STOP;
                  dn = 1'b1;
                  phase_nxt = PH_IDLE;
                end
              end else if (st == i2cees_pkg::ST_SLAR_NACK) begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                phase_nxt = PH_IDLE;
              end else if (st == i2cees_pkg::ST_ARB_LOST) begin
                act = i2cees_pkg::ACT_START;
                phase_nxt = PH_START;
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_RX: begin
              if (st == i2cees_pkg::ST_RX_ACK || st == i2cees_pkg::ST_RX_NACK) begin
                rv = 1'b1;
                rb = s1_rx_byte_r;
                transferred_nxt = transferred_r + 16'd1;
                remaining_nxt = rem_dec;
                if (st == i2cees_pkg::ST_RX_NACK || rem_dec == 16'd0) begin
                  act = i2cees_pkg::ACT_STOP;
                  dn = 1'b1;
                  phase_nxt = PH_IDLE;
                end else begin
                  act = (rem_dec > 16'd1) ? i2cees_pkg::ACT_RX_ACK
                                          : i2cees_pkg::ACT_RX_NAK;
                  phase_nxt = PH_RX;
                end
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            PH_TX: begin
              if (st == i2cees_pkg::ST_DATA_ACK) begin
                transferred_nxt = transferred_r + 16'd1;
                remaining_nxt = rem_dec;
                if (rem_dec != 16'd0) begin
                  act = i2cees_pkg::ACT_SEND;
                  tx = s1_write_byte_r;
                  taken = 1'b1;
                  phase_nxt = PH_TX;
                end else begin
                  act = i2cees_pkg::ACT_STOP;
                  dn = 1'b1;
                  phase_nxt = PH_IDLE;
                end
              end else begin
                act = i2cees_pkg::ACT_STOP;
                dn = 1'b1;
                fl = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      is_write_r    <= 1'b0;
      cur_address_r <= 16'd0;
      remaining_r   <= 16'd0;
      transferred_r <= 16'd0;
      attempts_r    <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        phase_r       <= phase_nxt;
        is_write_r    <= is_write_nxt;
        cur_address_r <= cur_address_nxt;
        remaining_r   <= remaining_nxt;
        transferred_r <= transferred_nxt;
        attempts_r    <= attempts_nxt;
      end
    end
    if (s1_adv) begin
      out_action_r <= act;
      out_tx_r     <= tx;
      out_taken_r  <= taken;
      out_rvalid_r <= rv;
      out_rbyte_r  <= rb;
      out_done_r   <= dn;
      out_failed_r <= fl;
      out_count_r  <= transferred_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bus_action  = out_action_r;
  assign out_tx_byte     = out_tx_r;
  assign out_write_taken = out_taken_r;
  assign out_read_valid  = out_rvalid_r;
  assign out_read_byte   = out_rbyte_r;
  assign out_done_res    = out_done_r;
  assign out_failed      = out_failed_r;
  assign out_byte_count  = out_count_r;

`ifndef SYNTHESIS
  a_fail_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_failed_r |-> out_done_r)
    else $error("failure reported without done");

  a_taken_is_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_taken_r |-> out_action_r == i2cees_pkg::ACT_SEND && !out_done_r)
    else $error("write byte taken without a send");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && dn |=> phase_r == PH_IDLE)
    else $error("sequencer busy after done");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_count_r == transferred_r)
    else $error("byte count out of step with state");
`endif

endmodule
